>>> sv/fra_pkg.sv
// ----------------------------------------------------------------------------
// fra_pkg: shared types and constants of the frame ring allocator
// Field widths, result status codes and the add/sub unit operation codes.
// ----------------------------------------------------------------------------
package fra_pkg;

	localparam int unsigned MAX_RECORDS_DEF = 256;
	localparam int unsigned ADDR_WIDTH_DEF  = 24;

	localparam int unsigned SIZE_W   = 25;
	localparam int unsigned ALIGN_W  = 17;
	localparam int unsigned FRAME_W  = 32;
	localparam int unsigned HEAP_W   = 25;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned FREED_W  = 9;

	localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(25'h100_0000);

	localparam logic OP_ALLOC    = 1'b0;
	localparam logic OP_FINALIZE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

	typedef enum logic {
		AS_ADD,
		AS_SUB
	} as_op_t;

endpackage

>>> sv/fra_addsub.sv
// ----------------------------------------------------------------------------
// fra_addsub: shared add/subtract unit
// Adds or subtracts two operands; on a subtract the carry is high when the
// first operand is not below the second.
// ----------------------------------------------------------------------------
module fra_addsub import fra_pkg::*; #(
	parameter int unsigned W = 27
) (
	input  as_op_t         op,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [W-1:0]   res,
	output logic           carry
);

	logic [W:0] sum;
	logic [W-1:0] b_eff;

	assign b_eff = (op == AS_SUB) ? ~b : b;
	assign sum   = {1'b0, a} + {1'b0, b_eff} + {{W{1'b0}}, (op == AS_SUB)};
	assign res   = sum[W-1:0];
	assign carry = sum[W];

endmodule

>>> sv/frame_ring_allocator_top.sv
// ----------------------------------------------------------------------------
// frame_ring_allocator_top: ring allocator with per-frame record retirement
// Sequence: a finalize with frame 0 or an empty ring, or a full-queue allocate,
// gives done from S_IDLE; an allocate runs S_NEED, then S_END, S_WRAP and maybe
// S_HEAP if records are live, then S_FIT1, S_FIT2 if needed and S_ALIGN on a
// grant; a finalize otherwise walks the oldest records in S_WALK one at a time.
// Throughput: one word at a time; busy is low again in the done cycle, so the
// next word can be taken there. The receiver never stalls a result. The shared
// add/sub unit and the single read port of the record memory force these steps.
// Reset is asynchronous: it empties the ring, clears the current frame and
// loads the full heap size.
// ----------------------------------------------------------------------------
module frame_ring_allocator_top import fra_pkg::*; #(
	parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int unsigned ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [HEAP_W-1:0]     cfg_wdata,
	input  logic                  start,
	output logic                  busy,
	input  logic                  op,
	input  logic [SIZE_W-1:0]     size,
	input  logic [ALIGN_W-1:0]    alignment,
	input  logic [FRAME_W-1:0]    frame_index,
	output logic                  done,
	output logic [STATUS_W-1:0]   status,
	output logic [ADDR_WIDTH-1:0] offset,
	output logic [FREED_W-1:0]    freed_count
);

	localparam int unsigned PW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
	localparam int unsigned UW = ((ADDR_WIDTH > SIZE_W) ? ADDR_WIDTH : SIZE_W) + 2;
	localparam logic [UW-1:0] CAP = UW'(1) << ADDR_WIDTH;
	localparam logic [PW-1:0] LAST_SLOT = PW'(MAX_RECORDS - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_RECORDS);

	typedef struct packed {
		logic [FRAME_W-1:0]    frame;
		logic [ADDR_WIDTH-1:0] off;
		logic [SIZE_W-1:0]     size;
	} rec_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_NEED,
		S_END,
		S_WRAP,
		S_HEAP,
		S_FIT1,
		S_FIT2,
		S_ALIGN,
		S_WALK
	} state_t;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + PW'(1);
	endfunction

	state_t               state_q;
	logic [PW-1:0]        oldest_q;
	logic [PW-1:0]        newest_q;
	logic [CW-1:0]        count_q;
	logic [FRAME_W-1:0]   cur_frame_q;
	logic [HEAP_W-1:0]    heap_q;
	logic [SIZE_W-1:0]    size_q;
	logic [ALIGN_W-1:0]   align_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [CW-1:0]        freed_q;
	logic [UW-1:0]        need_q;
	logic [UW-1:0]        start_q;
	logic [UW-1:0]        end_q;
	logic [UW-1:0]        end_gap_q;
	logic [UW-1:0]        start_gap_q;
	logic [UW-1:0]        base_q;

	rec_t                 mem [MAX_RECORDS];
	rec_t                 rdata_q;
	rec_t                 wdata;
	logic                 mem_we;
	logic [PW-1:0]        rd_addr;

	logic [UW-1:0]        heap_eff;
	logic [ALIGN_W-1:0]   align_m1;
	logic [ADDR_WIDTH-1:0] off_new;
	as_op_t               u_op;
	logic [UW-1:0]        u_a;
	logic [UW-1:0]        u_b;
	logic [UW-1:0]        u_res;
	logic                 u_carry;

	assign busy     = (state_q != S_IDLE);
	assign heap_eff = (UW'(heap_q) > CAP) ? CAP : UW'(heap_q);
	assign align_m1 = (align_q == '0) ? '0 : align_q - ALIGN_W'(1);
	assign off_new  = ADDR_WIDTH'(u_res & ~UW'(align_m1));
	assign mem_we   = (state_q == S_ALIGN);
	assign wdata    = '{frame: cur_frame_q, off: off_new, size: size_q};

	always_comb begin
		unique case (state_q)
			S_NEED:  rd_addr = (newest_q == '0) ? LAST_SLOT : newest_q - PW'(1);
			S_WALK:  rd_addr = next_slot(oldest_q);
			default: rd_addr = oldest_q;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_NEED: begin
				u_op = AS_ADD;
				u_a  = UW'(size_q);
				u_b  = UW'(align_q);
			end
			S_END: begin
				u_op = AS_ADD;
				u_a  = UW'(rdata_q.off);
				u_b  = UW'(rdata_q.size);
			end
			S_WRAP: begin
				u_op = AS_SUB;
				u_a  = start_q;
				u_b  = end_q;
			end
			S_HEAP: begin
				u_op = AS_SUB;
				u_a  = heap_eff;
				u_b  = end_q;
			end
			S_FIT1: begin
				u_op = AS_SUB;
				u_a  = end_gap_q;
				u_b  = need_q;
			end
			S_FIT2: begin
				u_op = AS_SUB;
				u_a  = start_gap_q;
				u_b  = need_q;
			end
			S_ALIGN: begin
				u_op = AS_ADD;
				u_a  = base_q;
				u_b  = UW'(align_m1);
			end
			default: begin
				u_op = AS_ADD;
				u_a  = '0;
				u_b  = '0;
			end
		endcase
	end

	fra_addsub #(
		.W(UW)
	) u_addsub (
		.op    (u_op),
		.a     (u_a),
		.b     (u_b),
		.res   (u_res),
		.carry (u_carry)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[newest_q] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			oldest_q    <= '0;
			newest_q    <= '0;
			count_q     <= '0;
			cur_frame_q <= '0;
			heap_q      <= HEAP_RESET;
			freed_q     <= '0;
			done        <= 1'b0;
			status      <= ST_OK;
			offset      <= '0;
			freed_count <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_we) begin
				heap_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						size_q  <= size;
						align_q <= alignment;
						frame_q <= frame_index;
						freed_q <= '0;
						if (op == OP_FINALIZE) begin
							if (frame_index != '0 && count_q != '0) begin
								state_q <= S_WALK;
							end else begin
								cur_frame_q <= frame_index;
								done        <= 1'b1;
								status      <= ST_OK;
								offset      <= '0;
								freed_count <= '0;
							end
						end else if (count_q == FULL_COUNT) begin
							done        <= 1'b1;
							status      <= ST_FULL;
							offset      <= '0;
							freed_count <= '0;
						end else begin
							state_q <= S_NEED;
						end
					end
				end
				S_NEED: begin
					need_q  <= u_res;
					start_q <= UW'(rdata_q.off);
					if (count_q == '0) begin
						end_q       <= '0;
						end_gap_q   <= heap_eff;
						start_gap_q <= '0;
						state_q     <= S_FIT1;
					end else begin
						state_q <= S_END;
					end
				end
				S_END: begin
					end_q   <= u_res;
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					if (u_carry) begin
						end_gap_q   <= u_res;
						start_gap_q <= '0;
						state_q     <= S_FIT1;
					end else begin
						start_gap_q <= start_q;
						state_q     <= S_HEAP;
					end
				end
				S_HEAP: begin
					end_gap_q <= u_carry ? u_res : '0;
					state_q   <= S_FIT1;
				end
				S_FIT1: begin
					if (u_carry) begin
						base_q  <= end_q;
						state_q <= S_ALIGN;
					end else begin
						state_q <= S_FIT2;
					end
				end
				S_FIT2: begin
					if (u_carry) begin
						base_q  <= '0;
						state_q <= S_ALIGN;
					end else begin
						done        <= 1'b1;
						status      <= ST_NO_SPACE;
						offset      <= '0;
						freed_count <= '0;
						state_q     <= S_IDLE;
					end
				end
				S_ALIGN: begin
					newest_q    <= next_slot(newest_q);
					count_q     <= count_q + CW'(1);
					done        <= 1'b1;
					status      <= ST_OK;
					offset      <= off_new;
					freed_count <= '0;
					state_q     <= S_IDLE;
				end
				S_WALK: begin
					if (count_q != '0 && rdata_q.frame < frame_q) begin
						oldest_q <= next_slot(oldest_q);
						count_q  <= count_q - CW'(1);
						freed_q  <= freed_q + CW'(1);
					end else begin
						cur_frame_q <= frame_q;
						done        <= 1'b1;
						status      <= ST_OK;
						offset      <= '0;
						freed_count <= FREED_W'(freed_q);
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The live record count never exceeds the ring depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("record count above ring depth");

	// A result word only follows an accepted or running command.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result word without a command");

	// The sequencer is free again whenever a result word is shown.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while a result word is shown");

	// A queue-full refusal is only given with a full ring.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count_q == FULL_COUNT))
		else $error("queue-full status with room in the ring");

	// A granted allocation adds exactly one record.
	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALIGN) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("grant did not add one record");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the frame ring allocator
// A short table of directed words at the reset heap size is followed by
// random phases over several heap sizes, one of which fills the record queue.
// Results are compared against typed table outcomes or a ring predictor.
// ----------------------------------------------------------------------------
module tb_top;
	import fra_pkg::*;

	localparam int unsigned          CYCLE_LIMIT = 500000;
	localparam longint unsigned      HEAP_CAP    = 64'd1 << ADDR_WIDTH_DEF;
	localparam logic [FRAME_W-1:0]   FRAME_TOP   = 32'hFFFF_FFFF;
	localparam logic [FRAME_W-1:0]   FRAME_CAP   = 32'hFFFF_FFF0;
	localparam int                   N_OPENING   = 22;

	typedef struct packed {
		logic               op;
		logic [SIZE_W-1:0]  size;
		logic [ALIGN_W-1:0] align;
		logic [FRAME_W-1:0] frame;
	} word_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       st;
		logic [ADDR_WIDTH_DEF-1:0] off;
		logic [FREED_W-1:0]        fr;
	} outcome_t;

	typedef struct packed {
		word_t    w;
		logic     typed;
		outcome_t res;
	} opening_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [HEAP_W-1:0]         cfg_wdata = '0;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      op = OP_ALLOC;
	logic [SIZE_W-1:0]         size = '0;
	logic [ALIGN_W-1:0]        alignment = '0;
	logic [FRAME_W-1:0]        frame_index = '0;
	logic                      done;
	logic [STATUS_W-1:0]       status;
	logic [ADDR_WIDTH_DEF-1:0] offset;
	logic [FREED_W-1:0]        freed_count;

	// Predicted ring state.
	logic [FRAME_W-1:0]        rec_frame [MAX_RECORDS_DEF];
	logic [ADDR_WIDTH_DEF-1:0] rec_off   [MAX_RECORDS_DEF];
	logic [SIZE_W-1:0]         rec_size  [MAX_RECORDS_DEF];
	logic [7:0]                oldest_slot = '0;
	logic [7:0]                fill_slot = '0;
	int unsigned               live_cnt = 0;
	logic [FRAME_W-1:0]        cur_frame = '0;
	logic [HEAP_W-1:0]         ring_heap = HEAP_RESET;

	outcome_t                  outcomes_due [$];
	outcome_t                  due;
	opening_row_t              opening_words [N_OPENING];
	logic [FRAME_W-1:0]        frame_base = 32'd1;
	int                        errors = 0;
	int unsigned               cycle_cnt = 0;
	int unsigned               n_grant = 0, n_space = 0, n_full = 0;
	int unsigned               n_fin = 0, n_freed = 0, n_heaps = 1;

	frame_ring_allocator_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.size       (size),
		.alignment  (alignment),
		.frame_index(frame_index),
		.done       (done),
		.status     (status),
		.offset     (offset),
		.freed_count(freed_count)
	);

	always #1 clk = ~clk;

	function automatic outcome_t ring_outcome(word_t w);
		outcome_t        r;
		longint unsigned heap, need, a, base, first, last, end_gap, start_gap, off;
		logic [7:0]      top_slot;
		bit              ok;
		r = '0;
		base = 0;
		ok = 1'b0;
		if (w.op == OP_FINALIZE) begin
			if (w.frame != 0) begin
				while (live_cnt != 0 && rec_frame[oldest_slot] < w.frame) begin
					oldest_slot = oldest_slot + 8'd1;
					live_cnt = live_cnt - 1;
					r.fr = r.fr + 1'b1;
				end
			end
			cur_frame = w.frame;
			n_fin++;
			n_freed += r.fr;
		end else if (live_cnt >= MAX_RECORDS_DEF) begin
			r.st = ST_FULL;
			n_full++;
		end else begin
			heap = (64'(ring_heap) > HEAP_CAP) ? HEAP_CAP : 64'(ring_heap);
			need = 64'(w.size) + 64'(w.align);
			a = (w.align == 0) ? 64'd1 : 64'(w.align);
			if (live_cnt == 0) begin
				ok = (need <= heap);
			end else begin
				top_slot = fill_slot - 8'd1;
				first = 64'(rec_off[oldest_slot]);
				last = 64'(rec_off[top_slot]) + 64'(rec_size[top_slot]);
				if (first < last) begin
					end_gap = (heap > last) ? heap - last : 64'd0;
					start_gap = first;
				end else begin
					end_gap = first - last;
					start_gap = 0;
				end
				if (end_gap >= need) begin
					base = last;
					ok = 1'b1;
				end else if (start_gap >= need) begin
					base = 0;
					ok = 1'b1;
				end
			end
			if (!ok) begin
				r.st = ST_NO_SPACE;
				n_space++;
			end else begin
				off = (base + a - 64'd1) & ~(a - 64'd1);
				r.off = off[ADDR_WIDTH_DEF-1:0];
				rec_frame[fill_slot] = cur_frame;
				rec_off[fill_slot] = off[ADDR_WIDTH_DEF-1:0];
				rec_size[fill_slot] = w.size;
				fill_slot = fill_slot + 8'd1;
				live_cnt = live_cnt + 1;
				n_grant++;
			end
		end
		return r;
	endfunction

	// Drives one word at a falling edge and waits for the edge that takes it.
	task automatic issue_word(word_t w, int gap, bit typed, outcome_t typed_res);
		outcome_t pred;
		if (gap > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		op = w.op;
		size = w.size;
		alignment = w.align;
		frame_index = w.frame;
		@(posedge clk);
		while (busy) @(posedge clk);
		pred = ring_outcome(w);
		outcomes_due.push_back(typed ? typed_res : pred);
	endtask

	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (outcomes_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_heap(logic [HEAP_W-1:0] v);
		drain();
		repeat (4) @(negedge clk);
		cfg_wdata = v;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		ring_heap = v;
		n_heaps++;
	endtask

	task automatic bump_frame();
		if (frame_base < FRAME_CAP)
			frame_base = frame_base + 1'b1;
	endtask

	task automatic make_word(output word_t w);
		int unsigned heap_eff, pick, lg;
		heap_eff = 32'((64'(ring_heap) > HEAP_CAP) ? HEAP_CAP : 64'(ring_heap));
		pick = $urandom_range(0, 99);
		w = '0;
		if (pick < 8) begin
			w.op = 1'($urandom);
			w.size = SIZE_W'($urandom);
			w.align = ALIGN_W'($urandom);
			w.frame = $urandom;
			if (w.op == OP_FINALIZE && w.frame > frame_base)
				frame_base = (w.frame > FRAME_CAP) ? FRAME_CAP : w.frame;
		end else if (pick < 20) begin
			w.op = OP_FINALIZE;
			w.frame = frame_base + $urandom_range(0, 2);
			if ($urandom_range(0, 1) == 1)
				bump_frame();
		end else begin
			w.op = OP_ALLOC;
			w.size = SIZE_W'($urandom_range(0, heap_eff / 6));
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				w.align = '0;
			end else if (pick == 1) begin
				w.align = ALIGN_W'($urandom_range(1, heap_eff / 8 + 1));
			end else begin
				lg = $urandom_range(0, 16);
				while (lg > 0 && (32'd1 << lg) > heap_eff / 8)
					lg--;
				w.align = 17'd1 << lg;
			end
		end
	endtask

	// Releases everything not stamped with the top frame, then restarts the
	// frame count at the running base.
	task automatic flush_ring();
		word_t w;
		w = '0;
		w.op = OP_FINALIZE;
		w.frame = FRAME_TOP;
		issue_word(w, 0, 1'b0, '0);
		w.frame = frame_base;
		issue_word(w, 0, 1'b0, '0);
	endtask

	task automatic run_phase(logic [HEAP_W-1:0] heap_v, int idle_pct, int n_words);
		word_t w;
		int    gap;
		set_heap(heap_v);
		flush_ring();
		repeat (n_words) begin
			make_word(w);
			gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
			if ($urandom_range(0, 49) == 0)
				drain();
			issue_word(w, gap, 1'b0, '0);
		end
	endtask

	// Fills all record slots in one frame, runs into the full queue, then
	// retires the whole queue with a single finalize.
	task automatic fill_phase(int idle_pct);
		word_t w;
		int    gap;
		set_heap(HEAP_RESET);
		flush_ring();
		repeat (MAX_RECORDS_DEF + 4) begin
			w = '0;
			w.op = OP_ALLOC;
			w.size = SIZE_W'($urandom_range(0, 1000));
			w.align = 17'd1 << $urandom_range(0, 4);
			gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 6) : 0;
			issue_word(w, gap, 1'b0, '0);
		end
		bump_frame();
		w = '0;
		w.op = OP_FINALIZE;
		w.frame = frame_base;
		issue_word(w, 0, 1'b0, '0);
	endtask

	always @(posedge clk) begin
		cycle_cnt = cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				$error("result word with no word outstanding");
				errors++;
			end else begin
				due = outcomes_due.pop_front();
				if (status !== due.st) begin
					$error("status: expected %0d, got %0d", due.st, status);
					errors++;
				end
				if (offset !== due.off) begin
					$error("offset: expected 0x%0h, got 0x%0h", due.off, offset);
					errors++;
				end
				if (freed_count !== due.fr) begin
					$error("freed_count: expected %0d, got %0d", due.fr, freed_count);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		int i;
		opening_words = '{
			'{'{OP_FINALIZE, 25'd0, 17'd0, 32'd0}, 1'b1, '{ST_OK, 24'd0, 9'd0}},
			'{'{OP_ALLOC, 25'd0, 17'd0, 32'd0}, 1'b1, '{ST_OK, 24'd0, 9'd0}},
			'{'{OP_ALLOC, 25'h100_0000, 17'd1, 32'd0}, 1'b1, '{ST_NO_SPACE, 24'd0, 9'd0}},
			'{'{OP_FINALIZE, 25'd0, 17'd0, 32'd1}, 1'b1, '{ST_OK, 24'd0, 9'd1}},
			'{'{OP_ALLOC, 25'hFF_FFFF, 17'd1, 32'd0}, 1'b1, '{ST_OK, 24'd0, 9'd0}},
			'{'{OP_ALLOC, 25'd1, 17'd1, 32'd0}, 1'b1, '{ST_NO_SPACE, 24'd0, 9'd0}},
			'{'{OP_FINALIZE, 25'd0, 17'd0, FRAME_TOP}, 1'b1, '{ST_OK, 24'd0, 9'd1}},
			'{'{OP_FINALIZE, 25'd0, 17'd0, 32'd0}, 1'b1, '{ST_OK, 24'd0, 9'd0}},
			'{'{OP_ALLOC, 25'd1000, 17'h1_0000, 32'd0}, 1'b1, '{ST_OK, 24'd0, 9'd0}},
			'{'{OP_ALLOC, 25'd10, 17'h1_0000, 32'd0}, 1'b0, '0},
			'{'{OP_ALLOC, 25'd5, 17'd3, 32'd0}, 1'b0, '0},
			'{'{OP_ALLOC, 25'h1FF_FFFF, 17'h1_FFFF, 32'd0}, 1'b1,
				'{ST_NO_SPACE, 24'd0, 9'd0}},
			'{'{OP_ALLOC, 25'd100, 17'd0, 32'd0}, 1'b0, '0},
			'{'{OP_FINALIZE, 25'd0, 17'd0, 32'd0}, 1'b1, '{ST_OK, 24'd0, 9'd0}},
			'{'{OP_FINALIZE, 25'd0, 17'd0, 32'd1}, 1'b0, '0},
			'{'{OP_ALLOC, 25'h1000, 17'h1_0000, 32'd0}, 1'b0, '0},
			'{'{OP_ALLOC, 25'h1FF_FFFF, 17'd1, 32'd0}, 1'b1, '{ST_NO_SPACE, 24'd0, 9'd0}},
			'{'{OP_FINALIZE, 25'd0, 17'd0, 32'd2}, 1'b0, '0},
			'{'{OP_ALLOC, 25'hAA_AAAA, 17'h100, 32'd0}, 1'b0, '0},
			'{'{OP_ALLOC, 25'h55_5555, 17'h8000, 32'd0}, 1'b0, '0},
			'{'{OP_FINALIZE, 25'd0, 17'd0, FRAME_TOP}, 1'b0, '0},
			'{'{OP_FINALIZE, 25'd0, 17'd0, 32'd0}, 1'b1, '{ST_OK, 24'd0, 9'd0}}
		};
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		for (i = 0; i < N_OPENING; i++)
			issue_word(opening_words[i].w, 0, opening_words[i].typed, opening_words[i].res);

		run_phase(25'd4096, 0, 120);
		run_phase(25'd4096, 61, 120);
		fill_phase(36);
		run_phase(25'h1FF_FFFF, 36, 60);
		run_phase(25'd0, 61, 30);
		run_phase(25'($urandom_range(256, 65536)), 0, 100);
		run_phase(HEAP_RESET, 61, 80);
		run_phase(25'($urandom), 36, 50);
		run_phase(25'd777, 61, 80);

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d granted allocations, %0d refused for space,",
			n_grant, n_space);
		$display("%0d refused on a full queue and %0d finalizes retiring %0d records %s %0d heaps.",
			n_full, n_fin, n_freed, "across", n_heaps);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/fra_pkg.sv
sv/fra_addsub.sv
sv/frame_ring_allocator_top.sv
tb/tb_top.sv
